// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the RTL of the decoder.
// Depends on nothing; the macros compile to nothing when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
		else $error("assertion failed: same-cycle implication");
// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
		else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLY(label, clk, rst_n, a, b)
`define ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

// ----- rtl/core/rvd_pkg.sv -----
// Types, opcodes and operation numbers of the RV32I/F variant decoder.
// Depends on nothing; used by every stage module and the top level.
package rvd_pkg;

	// major opcodes, bits 6:0
	localparam logic [6:0] OPC_BRANCH = 7'b1100011;
	localparam logic [6:0] OPC_LOAD   = 7'b0000011;
	localparam logic [6:0] OPC_STORE  = 7'b0100011;
	localparam logic [6:0] OPC_IMM    = 7'b0010011;
	localparam logic [6:0] OPC_OP     = 7'b0110011;
	localparam logic [6:0] OPC_LUI    = 7'b0110111;
	localparam logic [6:0] OPC_AUIPC  = 7'b0010111;
	localparam logic [6:0] OPC_JAL    = 7'b1101111;
	localparam logic [6:0] OPC_JALR   = 7'b1100111;
	localparam logic [6:0] OPC_NOP    = 7'b1111111;
	localparam logic [6:0] OPC_FLW    = 7'b0000111;
	localparam logic [6:0] OPC_FSW    = 7'b0100111;
	localparam logic [6:0] OPC_FOP    = 7'b1010011;

	// funct7 codes of the float opcode
	localparam logic [6:0] F7_FADD   = 7'h00;
	localparam logic [6:0] F7_FSUB   = 7'h04;
	localparam logic [6:0] F7_FMUL   = 7'h08;
	localparam logic [6:0] F7_FDIV   = 7'h0C;
	localparam logic [6:0] F7_FSQRT  = 7'h2C;
	localparam logic [6:0] F7_FSGNJ  = 7'h10;
	localparam logic [6:0] F7_FMINMAX = 7'h14;
	localparam logic [6:0] F7_FCVTWS = 7'h60;
	localparam logic [6:0] F7_FMVXW  = 7'h70;
	localparam logic [6:0] F7_FCMP   = 7'h50;
	localparam logic [6:0] F7_FCVTSW = 7'h68;
	localparam logic [6:0] F7_FMVWX  = 7'h78;

	// {funct7, funct3} codes of the register ALU opcode
	localparam logic [9:0] F10_ADD  = 10'h000;
	localparam logic [9:0] F10_SUB  = 10'h100;
	localparam logic [9:0] F10_SLL  = 10'h001;
	localparam logic [9:0] F10_SLT  = 10'h002;
	localparam logic [9:0] F10_SLTU = 10'h003;
	localparam logic [9:0] F10_XOR  = 10'h004;
	localparam logic [9:0] F10_SRL  = 10'h005;
	localparam logic [9:0] F10_SRA  = 10'h105;
	localparam logic [9:0] F10_OR   = 10'h006;
	localparam logic [9:0] F10_AND  = 10'h007;

	// operation numbers
	localparam logic [5:0] OP_NONE     = 6'd0;
	localparam logic [5:0] OP_BEQ      = 6'd1;
	localparam logic [5:0] OP_BNE      = 6'd2;
	localparam logic [5:0] OP_BGE      = 6'd3;
	localparam logic [5:0] OP_BLTU     = 6'd4;
	localparam logic [5:0] OP_BGEU     = 6'd5;
	localparam logic [5:0] OP_LB       = 6'd6;
	localparam logic [5:0] OP_LH       = 6'd7;
	localparam logic [5:0] OP_LW       = 6'd8;
	localparam logic [5:0] OP_LBU      = 6'd9;
	localparam logic [5:0] OP_LHU      = 6'd10;
	localparam logic [5:0] OP_SB       = 6'd11;
	localparam logic [5:0] OP_SH       = 6'd12;
	localparam logic [5:0] OP_SW       = 6'd13;
	localparam logic [5:0] OP_ADDI     = 6'd14;
	localparam logic [5:0] OP_SLTI     = 6'd15;
	localparam logic [5:0] OP_SLTIU    = 6'd16;
	localparam logic [5:0] OP_XORI     = 6'd17;
	localparam logic [5:0] OP_ORI      = 6'd18;
	localparam logic [5:0] OP_ANDI     = 6'd19;
	localparam logic [5:0] OP_ADD      = 6'd20;
	localparam logic [5:0] OP_SUB      = 6'd21;
	localparam logic [5:0] OP_SLL      = 6'd22;
	localparam logic [5:0] OP_SLT      = 6'd23;
	localparam logic [5:0] OP_SLTU     = 6'd24;
	localparam logic [5:0] OP_XOR      = 6'd25;
	localparam logic [5:0] OP_SRL      = 6'd26;
	localparam logic [5:0] OP_SRA      = 6'd27;
	localparam logic [5:0] OP_OR       = 6'd28;
	localparam logic [5:0] OP_AND      = 6'd29;
	localparam logic [5:0] OP_LUI      = 6'd30;
	localparam logic [5:0] OP_AUIPC    = 6'd31;
	localparam logic [5:0] OP_JAL      = 6'd32;
	localparam logic [5:0] OP_JALR     = 6'd33;
	localparam logic [5:0] OP_FLW      = 6'd34;
	localparam logic [5:0] OP_FSW      = 6'd35;
	localparam logic [5:0] OP_FADD     = 6'd36;
	localparam logic [5:0] OP_FSUB     = 6'd37;
	localparam logic [5:0] OP_FMUL     = 6'd38;
	localparam logic [5:0] OP_FDIV     = 6'd39;
	localparam logic [5:0] OP_FSQRT    = 6'd40;
	localparam logic [5:0] OP_FSGNJ    = 6'd41;
	localparam logic [5:0] OP_FSGNJN   = 6'd42;
	localparam logic [5:0] OP_FSGNJX   = 6'd43;
	localparam logic [5:0] OP_FMIN     = 6'd44;
	localparam logic [5:0] OP_FMAX     = 6'd45;
	localparam logic [5:0] OP_FCVT_W_S = 6'd46;
	localparam logic [5:0] OP_FCVT_WU_S = 6'd47;
	localparam logic [5:0] OP_FMV_X_W  = 6'd48;
	localparam logic [5:0] OP_FEQ      = 6'd49;
	localparam logic [5:0] OP_FLT      = 6'd50;
	localparam logic [5:0] OP_FLE      = 6'd51;
	localparam logic [5:0] OP_FCLASS   = 6'd52;
	localparam logic [5:0] OP_FCVT_S_W = 6'd53;
	localparam logic [5:0] OP_FCVT_S_WU = 6'd54;
	localparam logic [5:0] OP_FMV_W_X  = 6'd55;
	localparam logic [5:0] OP_NOP      = 6'd56;

	// status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_BAD_OPC   = 2'd1;
	localparam logic [1:0] ST_BAD_FUNCT = 2'd2;

	// opcode class found in the first stage
	typedef enum logic [3:0] {
		K_BRANCH, K_LOAD, K_STORE, K_IMM, K_OP, K_LUI, K_AUIPC,
		K_JAL, K_JALR, K_FLW, K_FSW, K_FOP, K_NOP, K_ILLEGAL
	} kind_t;

	// immediate layout picked in the second stage
	typedef enum logic [2:0] {
		IMM_NONE, IMM_I, IMM_S, IMM_U, IMM_J
	} imm_fmt_t;

	typedef struct packed {
		logic [31:0] word;
		kind_t       kind;
	} s1_t;

	typedef struct packed {
		logic [31:0] word;
		logic [5:0]  op;
		imm_fmt_t    fmt;
		logic        bad_opc;
	} s2_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] immediate;
		logic [4:0]  destination;
		logic [4:0]  source_two;
		logic [4:0]  source_one;
		logic [5:0]  operation;
	} res_t;

endpackage

// ----- rtl/core/rvd_classify.sv -----
// First pipeline stage: register the instruction word and its opcode class.
// Depends on rvd_pkg.
module rvd_classify (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  logic [31:0]  in_word,
	output logic         out_valid,
	input  logic         out_ready,
	output rvd_pkg::s1_t out_data
);

	logic         valid_s1;
	rvd_pkg::s1_t data_s1;
	rvd_pkg::kind_t kind;

	always_comb begin
		case (in_word[6:0])
			rvd_pkg::OPC_BRANCH: kind = rvd_pkg::K_BRANCH;
			rvd_pkg::OPC_LOAD:   kind = rvd_pkg::K_LOAD;
			rvd_pkg::OPC_STORE:  kind = rvd_pkg::K_STORE;
			rvd_pkg::OPC_IMM:    kind = rvd_pkg::K_IMM;
			rvd_pkg::OPC_OP:     kind = rvd_pkg::K_OP;
			rvd_pkg::OPC_LUI:    kind = rvd_pkg::K_LUI;
			rvd_pkg::OPC_AUIPC:  kind = rvd_pkg::K_AUIPC;
			rvd_pkg::OPC_JAL:    kind = rvd_pkg::K_JAL;
			rvd_pkg::OPC_JALR:   kind = rvd_pkg::K_JALR;
			rvd_pkg::OPC_FLW:    kind = rvd_pkg::K_FLW;
			rvd_pkg::OPC_FSW:    kind = rvd_pkg::K_FSW;
			rvd_pkg::OPC_FOP:    kind = rvd_pkg::K_FOP;
			rvd_pkg::OPC_NOP:    kind = rvd_pkg::K_NOP;
			default:             kind = rvd_pkg::K_ILLEGAL;
		endcase
	end

	assign in_ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1.word <= in_word;
			data_s1.kind <= kind;
		end
	end

	assign out_valid = valid_s1;
	assign out_data  = data_s1;

endmodule

// ----- rtl/core/rvd_select.sv -----
// Second pipeline stage: pick the operation number and immediate layout.
// Depends on rvd_pkg.
module rvd_select (
	input  logic         clk,
	input  logic         arst_n,
	input  logic [2:0]   rm,
	input  logic         in_valid,
	output logic         in_ready,
	input  rvd_pkg::s1_t in_data,
	output logic         out_valid,
	input  logic         out_ready,
	output rvd_pkg::s2_t out_data
);

	logic         valid_s2;
	rvd_pkg::s2_t data_s2;

	logic [2:0] f3;
	logic [6:0] f7;
	logic [4:0] rs2;
	logic       rm_ok;
	logic [5:0] op;
	rvd_pkg::imm_fmt_t fmt;
	logic       bad_opc;

	assign f3    = in_data.word[14:12];
	assign f7    = in_data.word[31:25];
	assign rs2   = in_data.word[24:20];
	assign rm_ok = (f3 == rm);

	always_comb begin
		op      = rvd_pkg::OP_NONE;
		fmt     = rvd_pkg::IMM_NONE;
		bad_opc = 1'b0;
		case (in_data.kind)
			rvd_pkg::K_BRANCH: begin
				fmt = rvd_pkg::IMM_S;
				case (f3)
					3'd0:    op = rvd_pkg::OP_BEQ;
					3'd4:    op = rvd_pkg::OP_BNE;
					3'd5:    op = rvd_pkg::OP_BGE;
					3'd6:    op = rvd_pkg::OP_BLTU;
					3'd7:    op = rvd_pkg::OP_BGEU;
					default: op = rvd_pkg::OP_NONE;
				endcase
			end
			rvd_pkg::K_LOAD: begin
				fmt = rvd_pkg::IMM_I;
				case (f3)
					3'd0:    op = rvd_pkg::OP_LB;
					3'd1:    op = rvd_pkg::OP_LH;
					3'd2:    op = rvd_pkg::OP_LW;
					3'd4:    op = rvd_pkg::OP_LBU;
					3'd5:    op = rvd_pkg::OP_LHU;
					default: op = rvd_pkg::OP_NONE;
				endcase
			end
			rvd_pkg::K_STORE: begin
				fmt = rvd_pkg::IMM_S;
				case (f3)
					3'd0:    op = rvd_pkg::OP_SB;
					3'd1:    op = rvd_pkg::OP_SH;
					3'd2:    op = rvd_pkg::OP_SW;
					default: op = rvd_pkg::OP_NONE;
				endcase
			end
			rvd_pkg::K_IMM: begin
				fmt = rvd_pkg::IMM_I;
				case (f3)
					3'd0:    op = rvd_pkg::OP_ADDI;
					3'd2:    op = rvd_pkg::OP_SLTI;
					3'd3:    op = rvd_pkg::OP_SLTIU;
					3'd4:    op = rvd_pkg::OP_XORI;
					3'd6:    op = rvd_pkg::OP_ORI;
					3'd7:    op = rvd_pkg::OP_ANDI;
					default: op = rvd_pkg::OP_NONE;
				endcase
			end
			rvd_pkg::K_OP: begin
				case ({f7, f3})
					rvd_pkg::F10_ADD:  op = rvd_pkg::OP_ADD;
					rvd_pkg::F10_SUB:  op = rvd_pkg::OP_SUB;
					rvd_pkg::F10_SLL:  op = rvd_pkg::OP_SLL;
					rvd_pkg::F10_SLT:  op = rvd_pkg::OP_SLT;
					rvd_pkg::F10_SLTU: op = rvd_pkg::OP_SLTU;
					rvd_pkg::F10_XOR:  op = rvd_pkg::OP_XOR;
					rvd_pkg::F10_SRL:  op = rvd_pkg::OP_SRL;
					rvd_pkg::F10_SRA:  op = rvd_pkg::OP_SRA;
					rvd_pkg::F10_OR:   op = rvd_pkg::OP_OR;
					rvd_pkg::F10_AND:  op = rvd_pkg::OP_AND;
					default:           op = rvd_pkg::OP_NONE;
				endcase
			end
			rvd_pkg::K_LUI: begin
				fmt = rvd_pkg::IMM_U;
				op  = rvd_pkg::OP_LUI;
			end
			rvd_pkg::K_AUIPC: begin
				fmt = rvd_pkg::IMM_U;
				op  = rvd_pkg::OP_AUIPC;
			end
			rvd_pkg::K_JAL: begin
				fmt = rvd_pkg::IMM_J;
				op  = rvd_pkg::OP_JAL;
			end
			rvd_pkg::K_JALR: begin
				fmt = rvd_pkg::IMM_I;
				if (f3 == 3'd0) op = rvd_pkg::OP_JALR;
			end
			rvd_pkg::K_FLW: begin
				fmt = rvd_pkg::IMM_I;
				if (f3 == 3'd2) op = rvd_pkg::OP_FLW;
			end
			rvd_pkg::K_FSW: begin
				fmt = rvd_pkg::IMM_S;
				if (f3 == 3'd2) op = rvd_pkg::OP_FSW;
			end
			rvd_pkg::K_FOP: begin
				case (f7)
					rvd_pkg::F7_FADD:  if (rm_ok) op = rvd_pkg::OP_FADD;
					rvd_pkg::F7_FSUB:  if (rm_ok) op = rvd_pkg::OP_FSUB;
					rvd_pkg::F7_FMUL:  if (rm_ok) op = rvd_pkg::OP_FMUL;
					rvd_pkg::F7_FDIV:  if (rm_ok) op = rvd_pkg::OP_FDIV;
					rvd_pkg::F7_FSQRT: if (rm_ok) op = rvd_pkg::OP_FSQRT;
					rvd_pkg::F7_FSGNJ: begin
						case (f3)
							3'd0:    op = rvd_pkg::OP_FSGNJ;
							3'd1:    op = rvd_pkg::OP_FSGNJN;
							3'd2:    op = rvd_pkg::OP_FSGNJX;
							default: op = rvd_pkg::OP_NONE;
						endcase
					end
					rvd_pkg::F7_FMINMAX: begin
						case (f3)
							3'd0:    op = rvd_pkg::OP_FMIN;
							3'd1:    op = rvd_pkg::OP_FMAX;
							default: op = rvd_pkg::OP_NONE;
						endcase
					end
					rvd_pkg::F7_FCVTWS: begin
						if (rm_ok && rs2 == 5'd0) op = rvd_pkg::OP_FCVT_W_S;
						else if (rm_ok && rs2 == 5'd1) op = rvd_pkg::OP_FCVT_WU_S;
					end
					rvd_pkg::F7_FMVXW: begin
						if (rs2 == 5'd0 && f3 == 3'd0) op = rvd_pkg::OP_FMV_X_W;
						else if (rs2 == 5'd0 && f3 == 3'd1) op = rvd_pkg::OP_FCLASS;
					end
					rvd_pkg::F7_FCMP: begin
						case (f3)
							3'd2:    op = rvd_pkg::OP_FEQ;
							3'd1:    op = rvd_pkg::OP_FLT;
							3'd0:    op = rvd_pkg::OP_FLE;
							default: op = rvd_pkg::OP_NONE;
						endcase
					end
					rvd_pkg::F7_FCVTSW: begin
						if (rm_ok && rs2 == 5'd0) op = rvd_pkg::OP_FCVT_S_W;
						else if (rm_ok && rs2 == 5'd1) op = rvd_pkg::OP_FCVT_S_WU;
					end
					rvd_pkg::F7_FMVWX: begin
						if (f3 == 3'd0 && rs2 == 5'd1) op = rvd_pkg::OP_FMV_W_X;
					end
					default: op = rvd_pkg::OP_NONE;
				endcase
			end
			rvd_pkg::K_NOP: op = rvd_pkg::OP_NOP;
			default: bad_opc = 1'b1;
		endcase
		// an undecoded word carries no immediate
		if (op == rvd_pkg::OP_NONE) fmt = rvd_pkg::IMM_NONE;
	end

	assign in_ready = !valid_s2 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (in_ready) begin
			valid_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s2.word    <= in_data.word;
			data_s2.op      <= op;
			data_s2.fmt     <= fmt;
			data_s2.bad_opc <= bad_opc;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = data_s2;

endmodule

// ----- rtl/core/rvd_format.sv -----
// Third pipeline stage: build the immediate and status, hold the result item.
// Depends on rvd_pkg.
module rvd_format (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  rvd_pkg::s2_t  in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output rvd_pkg::res_t out_data
);

	logic          valid_s3;
	rvd_pkg::res_t data_s3;
	logic [31:0]   imm;
	logic [1:0]    status;
	logic [31:0]   w;

	assign w = in_data.word;

	always_comb begin
		case (in_data.fmt)
			rvd_pkg::IMM_I: imm = {{20{w[31]}}, w[31:20]};
			rvd_pkg::IMM_S: imm = {{20{w[31]}}, w[31:25], w[11:7]};
			rvd_pkg::IMM_U: imm = {w[31:12], 12'b0};
			rvd_pkg::IMM_J: imm = {{12{w[31]}}, w[31:12]};
			default:        imm = 32'd0;
		endcase
		if (in_data.bad_opc) status = rvd_pkg::ST_BAD_OPC;
		else if (in_data.op == rvd_pkg::OP_NONE) status = rvd_pkg::ST_BAD_FUNCT;
		else status = rvd_pkg::ST_OK;
	end

	assign in_ready = !valid_s3 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (in_ready) begin
			valid_s3 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s3.operation   <= in_data.op;
			data_s3.source_one  <= w[19:15];
			data_s3.source_two  <= w[24:20];
			data_s3.destination <= w[11:7];
			data_s3.immediate   <= imm;
			data_s3.status      <= status;
		end
	end

	assign out_valid = valid_s3;
	assign out_data  = data_s3;

endmodule

// ----- rtl/core/rv32if_variant_instruction_decoder.sv -----
// Top level of the RV32I/F variant instruction decoder: three-stage pipeline.
// Depends on rvd_pkg, rvd_classify, rvd_select, rvd_format, assert_macros.svh.
//
//  channel  direction  handshake            payload
//  s_*      in         s_tvalid / s_tready  s_tdata[31:0]  instruction_word
//  m_*      out        m_tvalid / m_tready  m_tdata[55:0]  decoded result item
//  cfg_*    in         cfg_we               cfg_wdata[2:0] accepted_rounding_mode
//
// One item per cycle while m_tready stays high; the register stages are opcode class,
// operation select and immediate/status build.
// Each stage advances when its register is empty or the next stage takes its
// item, so a stall on m_tready backs up stage by stage and bubbles are squeezed.
// arst_n clears the stage valid bits and sets the rounding mode register to 0.
module rv32if_variant_instruction_decoder (
	input  logic        clk,
	input  logic        arst_n,
	// instruction_word [31:0]
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,
	// operation [5:0], source_one [10:6], source_two [15:11], destination [20:16],
	// immediate [52:21], status [54:53], zero fill [55]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_wdata
);

	`include "assert_macros.svh"

	logic [2:0] rm_q;

	logic          valid_1, ready_1;
	rvd_pkg::s1_t  data_1;
	logic          valid_2, ready_2;
	rvd_pkg::s2_t  data_2;
	rvd_pkg::res_t res;

	// Hold the rounding mode; the user must change it only while the pipeline is empty, the block does not enforce this.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rm_q <= 3'd0;
		end else if (cfg_we) begin
			rm_q <= cfg_wdata;
		end
	end

	// Stage 1: classify the major opcode.
	rvd_classify u_classify (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_word   (s_tdata),
		.out_valid (valid_1),
		.out_ready (ready_1),
		.out_data  (data_1)
	);

	// Stage 2: resolve funct3/funct7/rs2/rm into an operation number.
	rvd_select u_select (
		.clk       (clk),
		.arst_n    (arst_n),
		.rm        (rm_q),
		.in_valid  (valid_1),
		.in_ready  (ready_1),
		.in_data   (data_1),
		.out_valid (valid_2),
		.out_ready (ready_2),
		.out_data  (data_2)
	);

	// Stage 3: assemble immediate and status into the output register.
	rvd_format u_format (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_2),
		.in_ready  (ready_2),
		.in_data   (data_2),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (res)
	);

	// Pack the result fields from the lowest bit up.
	assign m_tdata = {1'b0, res.status, res.immediate, res.destination,
		res.source_two, res.source_one, res.operation};

	// An accepted item always lands in stage 1.
	`ASSERT_NEXT(a_accept_fills_s1, clk, arst_n, s_tvalid && s_tready, valid_1)
	// A stage-2 item blocked by the output stage stays put.
	`ASSERT_NEXT(a_s2_holds, clk, arst_n, valid_2 && !ready_2, valid_2 && $stable(data_2))
	// A failed decode carries neither an operation nor an immediate.
	`ASSERT_IMPLY(a_bad_is_empty, clk, arst_n, m_tvalid && res.status != rvd_pkg::ST_OK, res.operation == rvd_pkg::OP_NONE && res.immediate == 32'd0)
	// A good decode always names an operation.
	`ASSERT_IMPLY(a_ok_has_op, clk, arst_n, m_tvalid && res.status == rvd_pkg::ST_OK, res.operation != rvd_pkg::OP_NONE)

endmodule

// ----- verif/rvd_enc_pkg.sv -----
// Instruction encodings the decoder testbench needs beyond rvd_pkg: funct3 and rs2 codes,
// fused multiply-add opcodes, and an encoder that builds a legal word for an operation.
// Depends on rvd_pkg.
package rvd_enc_pkg;
	import rvd_pkg::*;

	// funct3 codes; this variant puts BNE at 4 and has no BLT
	localparam logic [2:0] F3_BEQ    = 3'd0;
	localparam logic [2:0] F3_BNE    = 3'd4;
	localparam logic [2:0] F3_BGE    = 3'd5;
	localparam logic [2:0] F3_BLTU   = 3'd6;
	localparam logic [2:0] F3_BGEU   = 3'd7;
	localparam logic [2:0] F3_LB     = 3'd0;
	localparam logic [2:0] F3_LH     = 3'd1;
	localparam logic [2:0] F3_LW     = 3'd2;
	localparam logic [2:0] F3_LBU    = 3'd4;
	localparam logic [2:0] F3_LHU    = 3'd5;
	localparam logic [2:0] F3_SB     = 3'd0;
	localparam logic [2:0] F3_SH     = 3'd1;
	localparam logic [2:0] F3_SW     = 3'd2;
	localparam logic [2:0] F3_ADDI   = 3'd0;
	localparam logic [2:0] F3_SLTI   = 3'd2;
	localparam logic [2:0] F3_SLTIU  = 3'd3;
	localparam logic [2:0] F3_XORI   = 3'd4;
	localparam logic [2:0] F3_ORI    = 3'd6;
	localparam logic [2:0] F3_ANDI   = 3'd7;
	localparam logic [2:0] F3_JALR   = 3'd0;
	localparam logic [2:0] F3_FWORD  = 3'd2;
	localparam logic [2:0] F3_FSGNJ  = 3'd0;
	localparam logic [2:0] F3_FSGNJN = 3'd1;
	localparam logic [2:0] F3_FSGNJX = 3'd2;
	localparam logic [2:0] F3_FMIN   = 3'd0;
	localparam logic [2:0] F3_FMAX   = 3'd1;
	localparam logic [2:0] F3_FMVXW  = 3'd0;
	localparam logic [2:0] F3_FCLASS = 3'd1;
	localparam logic [2:0] F3_FEQ    = 3'd2;
	localparam logic [2:0] F3_FLT    = 3'd1;
	localparam logic [2:0] F3_FLE    = 3'd0;
	localparam logic [2:0] F3_FMVWX  = 3'd0;

	// rs2 selects the integer type of a convert; FMV.W.X wants 1 here
	localparam logic [4:0] RS2_W       = 5'd0;
	localparam logic [4:0] RS2_WU      = 5'd1;
	localparam logic [4:0] RS2_FMV_W_X = 5'd1;

	// fused multiply-add opcodes, not decoded by this block
	localparam logic [6:0] OPC_FMADD  = 7'h43;
	localparam logic [6:0] OPC_FMSUB  = 7'h47;
	localparam logic [6:0] OPC_FNMSUB = 7'h4B;
	localparam logic [6:0] OPC_FNMADD = 7'h4F;

	function automatic logic [31:0] f3_word(logic [31:7] rest, logic [2:0] f3, logic [6:0] opc);
		return {rest[31:15], f3, rest[11:7], opc};
	endfunction

	function automatic logic [31:0] f10_word(logic [31:7] rest, logic [9:0] f10);
		return {f10[9:3], rest[24:15], f10[2:0], rest[11:7], OPC_OP};
	endfunction

	function automatic logic [31:0] fop_word(logic [31:7] rest, logic [6:0] f7, logic [4:0] rs2,
		logic [2:0] f3);
		return {f7, rs2, rest[19:15], f3, rest[11:7], OPC_FOP};
	endfunction

	// Build a word for op; fields the op leaves free come from rest, rm fills rm-checked ops.
	function automatic logic [31:0] encode_op(logic [5:0] op, logic [31:7] rest, logic [2:0] rm);
		logic [4:0] rs2;
		rs2 = rest[24:20];
		case (op)
			OP_BEQ:       return f3_word(rest, F3_BEQ, OPC_BRANCH);
			OP_BNE:       return f3_word(rest, F3_BNE, OPC_BRANCH);
			OP_BGE:       return f3_word(rest, F3_BGE, OPC_BRANCH);
			OP_BLTU:      return f3_word(rest, F3_BLTU, OPC_BRANCH);
			OP_BGEU:      return f3_word(rest, F3_BGEU, OPC_BRANCH);
			OP_LB:        return f3_word(rest, F3_LB, OPC_LOAD);
			OP_LH:        return f3_word(rest, F3_LH, OPC_LOAD);
			OP_LW:        return f3_word(rest, F3_LW, OPC_LOAD);
			OP_LBU:       return f3_word(rest, F3_LBU, OPC_LOAD);
			OP_LHU:       return f3_word(rest, F3_LHU, OPC_LOAD);
			OP_SB:        return f3_word(rest, F3_SB, OPC_STORE);
			OP_SH:        return f3_word(rest, F3_SH, OPC_STORE);
			OP_SW:        return f3_word(rest, F3_SW, OPC_STORE);
			OP_ADDI:      return f3_word(rest, F3_ADDI, OPC_IMM);
			OP_SLTI:      return f3_word(rest, F3_SLTI, OPC_IMM);
			OP_SLTIU:     return f3_word(rest, F3_SLTIU, OPC_IMM);
			OP_XORI:      return f3_word(rest, F3_XORI, OPC_IMM);
			OP_ORI:       return f3_word(rest, F3_ORI, OPC_IMM);
			OP_ANDI:      return f3_word(rest, F3_ANDI, OPC_IMM);
			OP_ADD:       return f10_word(rest, F10_ADD);
			OP_SUB:       return f10_word(rest, F10_SUB);
			OP_SLL:       return f10_word(rest, F10_SLL);
			OP_SLT:       return f10_word(rest, F10_SLT);
			OP_SLTU:      return f10_word(rest, F10_SLTU);
			OP_XOR:       return f10_word(rest, F10_XOR);
			OP_SRL:       return f10_word(rest, F10_SRL);
			OP_SRA:       return f10_word(rest, F10_SRA);
			OP_OR:        return f10_word(rest, F10_OR);
			OP_AND:       return f10_word(rest, F10_AND);
			OP_LUI:       return {rest, OPC_LUI};
			OP_AUIPC:     return {rest, OPC_AUIPC};
			OP_JAL:       return {rest, OPC_JAL};
			OP_JALR:      return f3_word(rest, F3_JALR, OPC_JALR);
			OP_FLW:       return f3_word(rest, F3_FWORD, OPC_FLW);
			OP_FSW:       return f3_word(rest, F3_FWORD, OPC_FSW);
			OP_FADD:      return fop_word(rest, F7_FADD, rs2, rm);
			OP_FSUB:      return fop_word(rest, F7_FSUB, rs2, rm);
			OP_FMUL:      return fop_word(rest, F7_FMUL, rs2, rm);
			OP_FDIV:      return fop_word(rest, F7_FDIV, rs2, rm);
			OP_FSQRT:     return fop_word(rest, F7_FSQRT, rs2, rm);
			OP_FSGNJ:     return fop_word(rest, F7_FSGNJ, rs2, F3_FSGNJ);
			OP_FSGNJN:    return fop_word(rest, F7_FSGNJ, rs2, F3_FSGNJN);
			OP_FSGNJX:    return fop_word(rest, F7_FSGNJ, rs2, F3_FSGNJX);
			OP_FMIN:      return fop_word(rest, F7_FMINMAX, rs2, F3_FMIN);
			OP_FMAX:      return fop_word(rest, F7_FMINMAX, rs2, F3_FMAX);
			OP_FCVT_W_S:  return fop_word(rest, F7_FCVTWS, RS2_W, rm);
			OP_FCVT_WU_S: return fop_word(rest, F7_FCVTWS, RS2_WU, rm);
			OP_FMV_X_W:   return fop_word(rest, F7_FMVXW, RS2_W, F3_FMVXW);
			OP_FEQ:       return fop_word(rest, F7_FCMP, rs2, F3_FEQ);
			OP_FLT:       return fop_word(rest, F7_FCMP, rs2, F3_FLT);
			OP_FLE:       return fop_word(rest, F7_FCMP, rs2, F3_FLE);
			OP_FCLASS:    return fop_word(rest, F7_FMVXW, RS2_W, F3_FCLASS);
			OP_FCVT_S_W:  return fop_word(rest, F7_FCVTSW, RS2_W, rm);
			OP_FCVT_S_WU: return fop_word(rest, F7_FCVTSW, RS2_WU, rm);
			OP_FMV_W_X:   return fop_word(rest, F7_FMVWX, RS2_FMV_W_X, F3_FMVWX);
			OP_NOP:       return {rest, OPC_NOP};
			default:      return '0;
		endcase
	endfunction

endpackage

// ----- verif/rvd_checker.sv -----
// Result checker of the instruction decoder: predicts each accepted instruction and
// compares the result items in order. Depends on rvd_pkg and rvd_enc_pkg.
module rvd_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [31:0] s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [55:0] m_tdata,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_wdata,
	output int          pending,
	output int          failures
);
	timeunit 1ns;
	timeprecision 1ps;
	import rvd_pkg::*;
	import rvd_enc_pkg::*;

	res_t       decoded_q[$];
	logic [2:0] rm_copy;

	function automatic res_t decode_word(logic [31:0] w, logic [2:0] rm);
		res_t        r;
		logic [2:0]  f3;
		logic [6:0]  f7;
		logic [4:0]  rs2;
		logic [31:0] imm_i;
		logic [31:0] imm_s;
		logic [31:0] imm;
		logic [5:0]  op;
		logic        rm_ok;
		logic        opc_known;
		f3 = w[14:12];
		f7 = w[31:25];
		rs2 = w[24:20];
		imm_i = {{20{w[31]}}, w[31:20]};
		imm_s = {{20{w[31]}}, w[31:25], w[11:7]};
		rm_ok = (f3 == rm);
		op = OP_NONE;
		imm = '0;
		opc_known = 1'b1;
		case (w[6:0])
			OPC_BRANCH: begin
				case (f3)
					F3_BEQ:  op = OP_BEQ;
					F3_BNE:  op = OP_BNE;
					F3_BGE:  op = OP_BGE;
					F3_BLTU: op = OP_BLTU;
					F3_BGEU: op = OP_BGEU;
					default: ;
				endcase
				imm = imm_s;
			end
			OPC_LOAD: begin
				case (f3)
					F3_LB:   op = OP_LB;
					F3_LH:   op = OP_LH;
					F3_LW:   op = OP_LW;
					F3_LBU:  op = OP_LBU;
					F3_LHU:  op = OP_LHU;
					default: ;
				endcase
				imm = imm_i;
			end
			OPC_STORE: begin
				case (f3)
					F3_SB:   op = OP_SB;
					F3_SH:   op = OP_SH;
					F3_SW:   op = OP_SW;
					default: ;
				endcase
				imm = imm_s;
			end
			OPC_IMM: begin
				case (f3)
					F3_ADDI:  op = OP_ADDI;
					F3_SLTI:  op = OP_SLTI;
					F3_SLTIU: op = OP_SLTIU;
					F3_XORI:  op = OP_XORI;
					F3_ORI:   op = OP_ORI;
					F3_ANDI:  op = OP_ANDI;
					default:  ;
				endcase
				imm = imm_i;
			end
			OPC_OP: begin
				case ({f7, f3})
					F10_ADD:  op = OP_ADD;
					F10_SUB:  op = OP_SUB;
					F10_SLL:  op = OP_SLL;
					F10_SLT:  op = OP_SLT;
					F10_SLTU: op = OP_SLTU;
					F10_XOR:  op = OP_XOR;
					F10_SRL:  op = OP_SRL;
					F10_SRA:  op = OP_SRA;
					F10_OR:   op = OP_OR;
					F10_AND:  op = OP_AND;
					default:  ;
				endcase
			end
			OPC_LUI: begin
				op = OP_LUI;
				imm = {w[31:12], 12'h000};
			end
			OPC_AUIPC: begin
				op = OP_AUIPC;
				imm = {w[31:12], 12'h000};
			end
			OPC_JAL: begin
				op = OP_JAL;
				imm = {{12{w[31]}}, w[31:12]};
			end
			OPC_JALR: begin
				if (f3 == F3_JALR) op = OP_JALR;
				imm = imm_i;
			end
			OPC_FLW: begin
				if (f3 == F3_FWORD) op = OP_FLW;
				imm = imm_i;
			end
			OPC_FSW: begin
				if (f3 == F3_FWORD) op = OP_FSW;
				imm = imm_s;
			end
			OPC_FOP: begin
				case (f7)
					F7_FADD:  if (rm_ok) op = OP_FADD;
					F7_FSUB:  if (rm_ok) op = OP_FSUB;
					F7_FMUL:  if (rm_ok) op = OP_FMUL;
					F7_FDIV:  if (rm_ok) op = OP_FDIV;
					F7_FSQRT: if (rm_ok) op = OP_FSQRT;
					F7_FSGNJ: begin
						if (f3 == F3_FSGNJ) op = OP_FSGNJ;
						else if (f3 == F3_FSGNJN) op = OP_FSGNJN;
						else if (f3 == F3_FSGNJX) op = OP_FSGNJX;
					end
					F7_FMINMAX: begin
						if (f3 == F3_FMIN) op = OP_FMIN;
						else if (f3 == F3_FMAX) op = OP_FMAX;
					end
					F7_FCVTWS: begin
						if (rm_ok && rs2 == RS2_W) op = OP_FCVT_W_S;
						else if (rm_ok && rs2 == RS2_WU) op = OP_FCVT_WU_S;
					end
					F7_FMVXW: begin
						if (rs2 == RS2_W && f3 == F3_FMVXW) op = OP_FMV_X_W;
						else if (rs2 == RS2_W && f3 == F3_FCLASS) op = OP_FCLASS;
					end
					F7_FCMP: begin
						if (f3 == F3_FEQ) op = OP_FEQ;
						else if (f3 == F3_FLT) op = OP_FLT;
						else if (f3 == F3_FLE) op = OP_FLE;
					end
					F7_FCVTSW: begin
						if (rm_ok && rs2 == RS2_W) op = OP_FCVT_S_W;
						else if (rm_ok && rs2 == RS2_WU) op = OP_FCVT_S_WU;
					end
					F7_FMVWX: if (f3 == F3_FMVWX && rs2 == RS2_FMV_W_X) op = OP_FMV_W_X;
					default: ;
				endcase
			end
			OPC_NOP: op = OP_NOP;
			default: opc_known = 1'b0;
		endcase
		r.source_one = w[19:15];
		r.source_two = w[24:20];
		r.destination = w[11:7];
		if (!opc_known) begin
			r.operation = OP_NONE;
			r.immediate = '0;
			r.status = ST_BAD_OPC;
		end else if (op == OP_NONE) begin
			r.operation = OP_NONE;
			r.immediate = '0;
			r.status = ST_BAD_FUNCT;
		end else begin
			r.operation = op;
			r.immediate = imm;
			r.status = ST_OK;
		end
		return r;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
			failures++;
		end
	endtask

	initial failures = 0;

	always @(posedge clk or negedge arst_n) begin : watch
		res_t want;
		res_t got;
		if (!arst_n) begin
			rm_copy = '0;
			decoded_q.delete();
			pending = 0;
		end else begin
			// the item sees the rounding mode from before this edge's write
			if (s_tvalid && s_tready)
				decoded_q.push_back(decode_word(s_tdata, rm_copy));
			if (cfg_we)
				rm_copy = cfg_wdata;
			if (m_tvalid && m_tready) begin
				got = res_t'(m_tdata[54:0]);
				if (decoded_q.size() == 0) begin
					$error("result item 0x%0h with no instruction waiting", m_tdata);
					failures++;
				end else begin
					want = decoded_q.pop_front();
					check_field("operation", want.operation, got.operation);
					check_field("source_one", want.source_one, got.source_one);
					check_field("source_two", want.source_two, got.source_two);
					check_field("destination", want.destination, got.destination);
					check_field("immediate", want.immediate, got.immediate);
					check_field("status", want.status, got.status);
				end
			end
			pending = decoded_q.size();
		end
	end

endmodule

// ----- verif/tb_top.sv -----
// Top of the instruction decoder testbench: clock, reset, instruction stimulus, rounding
// mode phases and the verdict. Depends on rvd_pkg, rvd_enc_pkg, rvd_checker and the RTL.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import rvd_pkg::*;
	import rvd_enc_pkg::*;

	localparam int PHASES = 5;
	localparam int PHASE_ITEMS = 225;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [55:0] m_tdata;
	logic        cfg_we;
	logic [2:0]  cfg_wdata;

	int          pending;
	int          failures;
	logic [2:0]  rounding_mode;   // value the block currently holds
	bit          s_burst;         // sender runs without gaps while set
	bit          m_burst;         // receiver runs without stalls while set

	rv32if_variant_instruction_decoder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	rvd_checker decode_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.pending   (pending),
		.failures  (failures)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Hard stop: the slowest legal run is well under a tenth of this.
	initial begin
		#2_000_000;
		$display("[rv32if_variant_instruction_decoder] ERROR");
		$finish;
	end

	// Offer one instruction item; hold it until the block takes it.
	// Valid only drops when a gap is drawn, so back-to-back items keep it high.
	task automatic send_item(input logic [31:0] word);
		int gap;
		if ($urandom_range(0, 39) == 0) s_burst = !s_burst;
		gap = s_burst ? 0 : $urandom_range(0, 5);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= word;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	// Drop valid and wait until every result has come back. The first edge lets the
	// checker record an item accepted at the edge the caller returned on.
	task automatic drain;
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	// Write the rounding mode; only called with the pipeline empty.
	task automatic write_mode(input logic [2:0] mode);
		cfg_we <= 1'b1;
		cfg_wdata <= mode;
		@(posedge clk);
		cfg_we <= 1'b0;
		rounding_mode = mode;
	endtask

	function automatic logic [6:0] any_opcode(int k);
		case (k)
			0:       return OPC_BRANCH;
			1:       return OPC_LOAD;
			2:       return OPC_STORE;
			3:       return OPC_IMM;
			4:       return OPC_OP;
			5:       return OPC_LUI;
			6:       return OPC_AUIPC;
			7:       return OPC_JAL;
			8:       return OPC_JALR;
			9:       return OPC_NOP;
			10:      return OPC_FLW;
			11:      return OPC_FSW;
			12:      return OPC_FOP;
			13:      return OPC_FMADD;
			14:      return OPC_FMSUB;
			15:      return OPC_FNMSUB;
			default: return OPC_FNMADD;
		endcase
	endfunction

	function automatic logic [6:0] any_fop_funct7(int k);
		case (k)
			0:       return F7_FADD;
			1:       return F7_FSUB;
			2:       return F7_FMUL;
			3:       return F7_FDIV;
			4:       return F7_FSQRT;
			5:       return F7_FSGNJ;
			6:       return F7_FMINMAX;
			7:       return F7_FCVTWS;
			8:       return F7_FMVXW;
			9:       return F7_FCMP;
			10:      return F7_FCVTSW;
			default: return F7_FMVWX;
		endcase
	endfunction

	// Mostly legal words with random free fields, some of them with a wrong rm;
	// the rest are near misses on a known opcode and plain random words.
	function automatic logic [31:0] random_word;
		logic [31:0] raw;
		logic [2:0]  rm;
		int          pick;
		raw = $urandom;
		pick = $urandom_range(0, 99);
		if (pick < 70) begin
			rm = ($urandom_range(0, 4) == 0) ? 3'($urandom_range(0, 7)) : rounding_mode;
			return encode_op(6'($urandom_range(1, 56)), raw[31:7], rm);
		end else if (pick < 80) begin
			return {raw[31:7], any_opcode($urandom_range(0, 16))};
		end else if (pick < 90) begin
			// known float funct7, small rs2 and any funct3: hits the operand checks
			return fop_word(raw[31:7], any_fop_funct7($urandom_range(0, 11)),
				5'($urandom_range(0, 3)), raw[14:12]);
		end
		return raw;
	endfunction

	// Receiver: stall a random number of cycles before each result item.
	initial begin : result_side
		int stall;
		m_tready = 1'b0;
		m_burst = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if ($urandom_range(0, 39) == 0) m_burst = !m_burst;
			stall = m_burst ? 0 : $urandom_range(0, 5);
			if (stall != 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
		end
	end

	initial begin
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		s_burst = 1'b0;
		rounding_mode = 3'd0;
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed items at the reset rounding mode.
		send_item(32'h0000_0000);                               // opcode zero is unknown
		send_item(32'hFFFF_FFFF);                               // all ones decodes as nop
		send_item(encode_op(OP_BNE, '1, 3'd0));                 // bne, offset all ones
		send_item(32'h0020_9063);                               // branch funct3 1: not decoded here
		send_item(encode_op(OP_BEQ, '0, 3'd0));
		send_item(encode_op(OP_JAL, {1'b1, 24'h0}, 3'd0));      // most negative jal offset
		send_item(encode_op(OP_JAL, {1'b0, {24{1'b1}}}, 3'd0)); // most positive jal offset
		send_item(encode_op(OP_LUI, '1, 3'd0));
		send_item(encode_op(OP_AUIPC, {1'b0, 24'h8A5F3C}, 3'd0));
		send_item(encode_op(OP_LW, {1'b1, 24'h0}, 3'd0));       // load offset -2048
		send_item(encode_op(OP_ADDI, {1'b0, {24{1'b1}}}, 3'd0)); // immediate +2047
		send_item(encode_op(OP_SW, '1, 3'd0));
		send_item(encode_op(OP_SRA, '1, 3'd0));
		send_item(32'h4000_1033);                               // sll with the sub/sra funct7
		send_item(encode_op(OP_FADD, '1, 3'd0));
		send_item(encode_op(OP_FADD, '1, 3'd5));                // rm differs from the register
		send_item(encode_op(OP_FSQRT, '1, 3'd0));               // rs2 is not checked
		send_item(32'hC020_0053);                               // fcvt.w.s with rs2 2
		send_item(32'hE010_0053);                               // fmv.x.w with rs2 1
		send_item(encode_op(OP_FMV_W_X, '0, 3'd0));
		send_item(32'hF000_0053);                               // fmv.w.x with rs2 0
		send_item(32'hFFFF_FFC3);                               // fused multiply-add
		send_item(32'h1234_564F);                               // fused negated multiply-add
		send_item(32'h0000_3007);                               // flw with funct3 3
		send_item(encode_op(OP_FCVT_S_WU, '1, 3'd0));

		// Random phases, each under its own rounding mode: both extremes first.
		for (int phase = 0; phase < PHASES; phase++) begin
			drain();
			case (phase)
				0:       write_mode(3'd7);
				1:       write_mode(3'd0);
				default: write_mode(3'($urandom_range(0, 7)));
			endcase
			for (int n = 0; n < PHASE_ITEMS; n++)
				send_item(random_word());
		end

		drain();
		// let a stray result from a broken pipeline show up
		repeat (8) @(posedge clk);
		if (failures == 0 && pending == 0)
			$display("[rv32if_variant_instruction_decoder] OK");
		else
			$display("[rv32if_variant_instruction_decoder] ERROR");
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/rvd_pkg.sv
rtl/core/rvd_classify.sv
rtl/core/rvd_select.sv
rtl/core/rvd_format.sv
rtl/core/rv32if_variant_instruction_decoder.sv
verif/rvd_enc_pkg.sv
verif/rvd_checker.sv
verif/tb_top.sv
